/* src/averaging_period_frequency_meter_defines.svh */
// Assertion macros shared by the frequency meter RTL.
`ifndef AVERAGING_PERIOD_FREQUENCY_METER_DEFINES_SVH
`define AVERAGING_PERIOD_FREQUENCY_METER_DEFINES_SVH

// Same-cycle implication, clocked on clk and idle while arst_n is low.
`define APFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and idle while arst_n is low.
`define APFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/apfm_pkg.sv */
// Types and constants of the averaging period frequency meter.
package apfm_pkg;

	// Field and state widths.
	localparam int STAMP_W    = 32;
	localparam int FREQ_W     = 24;
	localparam int COUNT_W    = 5;
	localparam int SUM_W      = 43;
	localparam int RAW_W      = 39;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 29;

	// Serial divider widths; the counter must hold DIVD_W itself.
	localparam int DIVD_W    = 43;
	localparam int DIVS_W    = 32;
	localparam int DIV_CNT_W = 6;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUTOFF    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUTOFF   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 2'd3;

	// Hertz to millihertz scale factor.
	localparam logic [RAW_W-1:0] MHZ_PER_HZ = 39'd1000;

	// Reset values; the clock is kept already scaled to millihertz.
	localparam logic [RAW_W-1:0]   CLK_X1000_RST = 39'd100000000000;
	localparam logic [FREQ_W-1:0]  LOW_RST       = 24'd70000;
	localparam logic [FREQ_W-1:0]  HIGH_RST      = 24'd9999900;
	localparam logic [COUNT_W-1:0] AVG_RST       = 5'd10;
	localparam logic [COUNT_W-1:0] AVG_MIN       = 5'd1;
	localparam logic [COUNT_W-1:0] AVG_MAX       = 5'd16;

	// Request to the serial divider.
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	// Status and result of the serial divider.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* src/apfm_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module apfm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  apfm_pkg::div_req_t req,
	output apfm_pkg::div_rsp_t rsp
);
	import apfm_pkg::*;

	logic [DIVS_W-1:0]    rem_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVS_W:0]      trial;
	logic [DIVS_W:0]      diff;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	// Iteration control; done pulses once after the last bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and the dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* src/averaging_period_frequency_meter.sv */
// Top level of the averaging period frequency meter.
//
// The capture channel takes one counter timestamp per rising edge of the
// measured signal (capture_valid / capture_stall); the result channel gives
// one item per capture item (result_valid / result_stall): the current
// frequency in millihertz and a flag telling whether this edge changed it.
// Edges pair up: the first only stores its stamp, the second forms the period
// and divides the scaled timer clock by it in a bit-serial divider, one bit a
// cycle. When a block of samples completes, the same divider forms the mean.
// One item is worked on at a time; the next capture item is taken the cycle
// after the result register is loaded.
// A result waits in its output register while result_stall is high; the
// block finishes and holds its next item until that register is taken.
// Reset clears the pairing, the running sum and count, the current frequency
// and restores the default configuration.
`include "averaging_period_frequency_meter_defines.svh"

module averaging_period_frequency_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [apfm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apfm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 capture_valid,
	output logic                                 capture_stall,
	input  logic [apfm_pkg::STAMP_W-1:0]         capture_time,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [apfm_pkg::FREQ_W-1:0]          frequency_mhz,
	output logic                                 updated
);
	import apfm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV1 = 3'd1;
	localparam logic [2:0] ST_DIV2 = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]         state_q;
	logic [RAW_W-1:0]   clk_x1000_q;
	logic [FREQ_W-1:0]  low_q;
	logic [FREQ_W-1:0]  high_q;
	logic [COUNT_W-1:0] avg_q;
	logic               edge_pending_q;
	logic [STAMP_W-1:0] first_time_q;
	logic [SUM_W-1:0]   sample_sum_q;
	logic [COUNT_W-1:0] sample_count_q;
	logic [FREQ_W-1:0]  cur_q;
	logic               upd_q;
	logic               result_valid_q;
	logic [FREQ_W-1:0]  frequency_mhz_q;
	logic               updated_q;

	logic               capture_fire;
	logic               emit_load;
	logic [STAMP_W-1:0] period;
	logic [RAW_W-1:0]   f_raw;
	logic               below_low;
	logic [SUM_W-1:0]   sum_n;
	logic [COUNT_W-1:0] count_n;
	logic [COUNT_W-1:0] eff_count;
	logic               avg_done;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	apfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Handshakes.
	assign capture_stall = (state_q != ST_IDLE);
	assign capture_fire  = capture_valid && !capture_stall;
	assign emit_load     = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);

	// Period, raw frequency and the running average update.
	assign period    = capture_time - first_time_q;
	assign f_raw     = div_rsp.quotient[RAW_W-1:0];
	assign below_low = (f_raw < RAW_W'(low_q));
	assign sum_n     = sample_sum_q + SUM_W'(f_raw);
	assign count_n   = sample_count_q + 1'b1;

	// Samples per average, with zero acting as one and large values clipped.
	always_comb begin
		if (avg_q == '0) begin
			eff_count = AVG_MIN;
		end else if (avg_q > AVG_MAX) begin
			eff_count = AVG_MAX;
		end else begin
			eff_count = avg_q;
		end
	end

	assign avg_done = (count_n >= eff_count);

	// Divider requests: the frequency division, then the mean division.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = SUM_W'(clk_x1000_q);
		div_req.divisor  = period;
		if (state_q == ST_DIV1) begin
			div_req.dividend = sum_n;
			div_req.divisor  = DIVS_W'(count_n);
			div_req.start    = div_rsp.done && !below_low && avg_done;
		end else if (state_q == ST_IDLE) begin
			div_req.start = capture_fire && edge_pending_q && (period != '0);
		end
	end

	// Configuration registers; the timer clock is kept scaled to millihertz.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_x1000_q <= CLK_X1000_RST;
			low_q       <= LOW_RST;
			high_q      <= HIGH_RST;
			avg_q       <= AVG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMER_CLOCK:   clk_x1000_q <= RAW_W'(cfg_data) * MHZ_PER_HZ;
				CFG_LOW_CUTOFF:    low_q       <= cfg_data[FREQ_W-1:0];
				CFG_HIGH_CUTOFF:   high_q      <= cfg_data[FREQ_W-1:0];
				CFG_AVERAGE_COUNT: avg_q       <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// First stamp of a pair.
	always_ff @(posedge clk) begin
		if (capture_fire && !edge_pending_q) begin
			first_time_q <= capture_time;
		end
	end

	// Sequencer and measurement state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			edge_pending_q <= 1'b0;
			sample_sum_q   <= '0;
			sample_count_q <= '0;
			cur_q          <= '0;
			upd_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// The output register fills on a load and empties when its item is taken.
			if (emit_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (capture_fire) begin
						edge_pending_q <= !edge_pending_q;
						if (!edge_pending_q) begin
							upd_q   <= 1'b0;
							state_q <= ST_EMIT;
						end else if (period == '0) begin
							cur_q   <= '0;
							upd_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							upd_q   <= 1'b0;
							state_q <= ST_DIV1;
						end
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						if (below_low) begin
							cur_q          <= f_raw[FREQ_W-1:0];
							sample_sum_q   <= '0;
							sample_count_q <= '0;
							upd_q          <= 1'b1;
							state_q        <= ST_CHK;
						end else if (avg_done) begin
							sample_sum_q   <= '0;
							sample_count_q <= '0;
							state_q        <= ST_DIV2;
						end else begin
							sample_sum_q   <= sum_n;
							sample_count_q <= count_n;
							state_q        <= ST_CHK;
						end
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient > SUM_W'(high_q)) begin
							cur_q <= '0;
						end else begin
							cur_q <= div_rsp.quotient[FREQ_W-1:0];
						end
						upd_q   <= 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (cur_q > high_q) begin
						cur_q <= '0;
						upd_q <= 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			frequency_mhz_q <= cur_q;
			updated_q       <= upd_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign frequency_mhz = frequency_mhz_q;
	assign updated       = updated_q;

	// Checks on the sequencer and the divider hand-off.
	`APFM_ASSERT_NOW(a_div_done_waited, div_rsp.done,
		(state_q == ST_DIV1) || (state_q == ST_DIV2),
		"divider finished while no division was awaited")
	`APFM_ASSERT_NOW(a_div_start_free, div_req.start, !div_rsp.busy,
		"divider started while busy")
	`APFM_ASSERT_NOW(a_count_bound, 1'b1, sample_count_q <= AVG_MAX,
		"sample count beyond block size")
	`APFM_ASSERT_NEXT(a_emit_shows, emit_load, result_valid && (state_q == ST_IDLE),
		"loaded result not presented")

endmodule
